// File: rtl/cskd_pkg.sv
`default_nettype none
package cskd_pkg;

   // Input and result transaction payloads.
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] char_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } rsp_type;

   // Input kinds.
   localparam logic [1:0] KIND_TEXT = 2'd0;
   localparam logic [1:0] KIND_EOL  = 2'd1;
   localparam logic [1:0] KIND_EOS  = 2'd2;

   // Classified operations passed from the front to the back.
   localparam logic [1:0] OP_TEXT = 2'd0;
   localparam logic [1:0] OP_EOL  = 2'd1;
   localparam logic [1:0] OP_EOS  = 2'd2;
   localparam logic [1:0] OP_NONE = 2'd3;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] char_byte;
   } cmd_type;

   // Characters of interest.
   localparam logic [7:0] CH_STAR  = 8'd42;
   localparam logic [7:0] CH_SLASH = 8'd47;
   localparam logic [7:0] CH_BANG  = 8'd33;
   localparam logic [7:0] CH_NL    = 8'd10;

   // Whitespace test: space, tab, newline, vertical tab, form feed, carriage return.
   function automatic logic is_white(input logic [7:0] c);
      is_white = (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
   endfunction

endpackage
`default_nettype wire

// File: rtl/cskd_front.sv
`default_nettype none
module cskd_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire cskd_pkg::req_type req_data,
   output logic                  cmd_valid,
   input  wire logic             cmd_ready,
   output cskd_pkg::cmd_type     cmd_data
);
   import cskd_pkg::*;

   cmd_type    q_ff [4];
   logic [1:0] wp_ff, wp_in;
   logic [1:0] rp_ff, rp_in;
   logic [2:0] cnt_ff, cnt_in;
   cmd_type    cls;
   logic       push, pop;

   // Classify the incoming transaction.
   always_comb begin
      cls.char_byte = req_data.char_byte;
      unique case (req_data.kind)
         KIND_TEXT: cls.op = OP_TEXT;
         KIND_EOL:  cls.op = OP_EOL;
         KIND_EOS:  cls.op = OP_EOS;
         default:   cls.op = OP_NONE;
      endcase
   end

   // Queue control.
   assign req_ready = (cnt_ff != 3'd4);
   assign cmd_valid = (cnt_ff != 3'd0);
   assign cmd_data  = q_ff[rp_ff];
   assign push      = req_valid && req_ready;
   assign pop       = cmd_valid && cmd_ready;

   always_comb begin
      wp_in  = push ? wp_ff + 2'd1 : wp_ff;
      rp_in  = pop ? rp_ff + 2'd1 : rp_ff;
      cnt_in = cnt_ff + {2'b0, push} - {2'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 2'd0;
         rp_ff  <= 2'd0;
         cnt_ff <= 3'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= cls;
      end
   end

endmodule
`default_nettype wire

// File: rtl/cskd_back.sv
`default_nettype none
module cskd_back #(
   parameter int SPACE_DEPTH = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              cmd_valid,
   output logic                   cmd_ready,
   input  wire cskd_pkg::cmd_type cmd_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output cskd_pkg::rsp_type      rsp_data
);
   import cskd_pkg::*;

   localparam int HW = (SPACE_DEPTH > 1) ? $clog2(SPACE_DEPTH) : 1;
   localparam int CW = $clog2(SPACE_DEPTH + 1);
   localparam int SW = CW + 1;
   localparam logic [CW-1:0] DEPTH_C = CW'(SPACE_DEPTH);
   localparam logic [HW-1:0] LAST_H  = HW'(SPACE_DEPTH - 1);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_DEC  = 4'd1;
   localparam logic [3:0] S_EMIT = 4'd2;
   localparam logic [3:0] S_FRD  = 4'd3;
   localparam logic [3:0] S_FWR  = 4'd4;
   localparam logic [3:0] S_EOL  = 4'd5;
   localparam logic [3:0] S_ENL  = 4'd6;
   localparam logic [3:0] S_FIN  = 4'd7;

   localparam logic [1:0] RET_WFULL = 2'd0;
   localparam logic [1:0] RET_CHAR  = 2'd1;
   localparam logic [1:0] RET_EOL   = 2'd2;

   localparam logic [1:0] R_WAIT = 2'd0;
   localparam logic [1:0] R_ONE  = 2'd1;
   localparam logic [1:0] R_TWO  = 2'd2;
   localparam logic [1:0] R_SKIP = 2'd3;

   logic [3:0]    st_ff, st_in;
   logic          inblk_ff, inblk_in, keep_ff, keep_in, plb_ff, plb_in;
   logic          lho_ff, lho_in, skip_ff, skip_in;
   logic [7:0]    la_ff [4];
   logic [7:0]    la_in [4];
   logic [2:0]    n_ff, n_in;
   logic          fin_ff, fin_in, eol_ff, eol_in, nl_ff, nl_in, eos_ff, eos_in;
   logic [7:0]    e0_ff, e0_in, e1_ff, e1_in;
   logic [1:0]    ecnt_ff, ecnt_in;
   logic          eidx_ff, eidx_in;
   logic [1:0]    ret_ff, ret_in;
   logic          has_ff, has_in;
   logic [HW-1:0] head_ff, head_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          hold_v_ff, hold_v_in;
   logic [7:0]    hold_ff, hold_in;
   logic          out_v_ff, out_v_in;
   rsp_type       out_ff, out_in;

   logic [7:0]    sp_mem [SPACE_DEPTH];
   logic [7:0]    rd_q_ff;
   logic          wr_en;
   logic [HW-1:0] wr_addr;
   logic [7:0]    wr_data;

   logic [1:0]    dec_r;
   logic [7:0]    dec_e0, dec_e1;
   logic [1:0]    dec_ecnt;
   logic          dec_inblk, dec_keep;
   logic          doc, wait_more;

   logic          can_push, push, prod_ok, prod_req;
   logic [7:0]    prod_byte;
   rsp_type       push_data;
   logic [7:0]    cur_c;
   logic [SW-1:0] tail_sum;
   logic [HW-1:0] tail, head_inc;

   // Decision on the head of the lookahead window.
   always_comb begin
      dec_r     = R_ONE;
      dec_e0    = la_ff[0];
      dec_e1    = la_ff[0];
      dec_ecnt  = 2'd1;
      dec_inblk = inblk_ff;
      dec_keep  = keep_ff;
      doc       = 1'b0;
      wait_more = 1'b0;
      if (inblk_ff) begin
         if (la_ff[0] == CH_STAR && n_ff < 3'd2 && !fin_ff) begin
            dec_r = R_WAIT;
         end else if (la_ff[0] == CH_STAR && n_ff >= 3'd2 && la_ff[1] == CH_SLASH) begin
            dec_r     = R_TWO;
            dec_e0    = CH_STAR;
            dec_e1    = CH_SLASH;
            dec_ecnt  = keep_ff ? 2'd2 : 2'd0;
            dec_inblk = 1'b0;
            dec_keep  = 1'b0;
         end else begin
            dec_ecnt = keep_ff ? 2'd1 : 2'd0;
         end
      end else if (la_ff[0] == CH_SLASH) begin
         if (n_ff < 3'd2) begin
            if (!fin_ff) begin
               dec_r = R_WAIT;
            end
         end else if (la_ff[1] == CH_STAR) begin
            if (n_ff < 3'd3) begin
               wait_more = !fin_ff;
            end else if (la_ff[2] == CH_BANG) begin
               doc = 1'b1;
            end else if (la_ff[2] == CH_STAR) begin
               if (n_ff < 3'd4) begin
                  wait_more = !fin_ff;
                  doc       = 1'b1;
               end else begin
                  doc = (la_ff[3] != CH_SLASH);
               end
            end
            if (wait_more) begin
               dec_r = R_WAIT;
            end else begin
               dec_r     = R_TWO;
               dec_e0    = CH_SLASH;
               dec_e1    = CH_STAR;
               dec_ecnt  = doc ? 2'd2 : 2'd0;
               dec_inblk = 1'b1;
               dec_keep  = doc;
            end
         end else if (la_ff[1] == CH_SLASH) begin
            if (n_ff < 3'd3) begin
               dec_r = fin_ff ? R_SKIP : R_WAIT;
            end else if (la_ff[2] == CH_SLASH || la_ff[2] == CH_BANG) begin
               dec_r    = R_TWO;
               dec_e0   = CH_SLASH;
               dec_e1   = CH_SLASH;
               dec_ecnt = 2'd2;
            end else begin
               dec_r = R_SKIP;
            end
         end
      end
   end

   // Output register and the one-byte hold that lets the last flag be set late.
   assign can_push  = !out_v_ff || rsp_ready;
   assign prod_ok   = !hold_v_ff || can_push;
   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;
   assign cmd_ready = (st_ff == S_IDLE);
   assign cur_c     = eidx_ff ? e1_ff : e0_ff;
   assign tail_sum  = SW'(head_ff) + SW'(cnt_ff);
   assign tail      = (tail_sum >= SW'(SPACE_DEPTH)) ?
                      HW'(tail_sum - SW'(SPACE_DEPTH)) : HW'(tail_sum);
   assign head_inc  = (head_ff == LAST_H) ? '0 : head_ff + HW'(1);

   // Sequencer for one transaction.
   always_comb begin
      st_in     = st_ff;
      inblk_in  = inblk_ff;
      keep_in   = keep_ff;
      plb_in    = plb_ff;
      lho_in    = lho_ff;
      skip_in   = skip_ff;
      la_in     = la_ff;
      n_in      = n_ff;
      fin_in    = fin_ff;
      eol_in    = eol_ff;
      nl_in     = nl_ff;
      eos_in    = eos_ff;
      e0_in     = e0_ff;
      e1_in     = e1_ff;
      ecnt_in   = ecnt_ff;
      eidx_in   = eidx_ff;
      ret_in    = ret_ff;
      has_in    = has_ff;
      head_in   = head_ff;
      cnt_in    = cnt_ff;
      prod_req  = 1'b0;
      prod_byte = cur_c;
      push      = 1'b0;
      push_data = '{out_byte: hold_ff, last: 1'b0};
      wr_en     = 1'b0;
      wr_addr   = tail;
      wr_data   = cur_c;

      unique case (st_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               eidx_in = 1'b0;
               unique case (cmd_data.op)
                  OP_TEXT: begin
                     fin_in = 1'b0;
                     eol_in = 1'b0;
                     if (skip_ff) begin
                        st_in = S_FIN;
                     end else begin
                        la_in[n_ff[1:0]] = cmd_data.char_byte;
                        n_in  = n_ff + 3'd1;
                        st_in = S_DEC;
                     end
                  end
                  OP_EOL, OP_EOS: begin
                     fin_in = 1'b1;
                     eol_in = 1'b1;
                     nl_in  = (cmd_data.op == OP_EOL);
                     eos_in = (cmd_data.op == OP_EOS);
                     st_in  = S_DEC;
                  end
                  default: st_in = S_FIN;
               endcase
            end
         end
         S_DEC: begin
            eidx_in = 1'b0;
            if (n_ff == 3'd0 || skip_ff || dec_r == R_WAIT) begin
               st_in = eol_ff ? S_EOL : S_FIN;
            end else if (dec_r == R_SKIP) begin
               skip_in = 1'b1;
               n_in    = 3'd0;
               st_in   = eol_ff ? S_EOL : S_FIN;
            end else begin
               inblk_in = dec_inblk;
               keep_in  = dec_keep;
               e0_in    = dec_e0;
               e1_in    = dec_e1;
               ecnt_in  = dec_ecnt;
               if (dec_r == R_TWO) begin
                  la_in[0] = la_ff[2];
                  la_in[1] = la_ff[3];
                  n_in     = (n_ff >= 3'd2) ? n_ff - 3'd2 : 3'd0;
               end else begin
                  la_in[0] = la_ff[1];
                  la_in[1] = la_ff[2];
                  la_in[2] = la_ff[3];
                  n_in     = n_ff - 3'd1;
               end
               if (dec_ecnt != 2'd0) begin
                  st_in = S_EMIT;
               end
            end
         end
         S_EMIT: begin
            if (is_white(cur_c)) begin
               if (cnt_ff == DEPTH_C) begin
                  ret_in = RET_WFULL;
                  st_in  = S_FRD;
               end else begin
                  wr_en  = 1'b1;
                  cnt_in = cnt_ff + CW'(1);
                  if (!eidx_ff && ecnt_ff == 2'd2) begin
                     eidx_in = 1'b1;
                  end else begin
                     st_in = S_DEC;
                  end
               end
            end else if (cnt_ff != '0) begin
               ret_in = RET_CHAR;
               st_in  = S_FRD;
            end else if (prod_ok) begin
               prod_req = 1'b1;
               lho_in   = 1'b1;
               if (!eidx_ff && ecnt_ff == 2'd2) begin
                  eidx_in = 1'b1;
               end else begin
                  st_in = S_DEC;
               end
            end
         end
         S_FRD: begin
            st_in = S_FWR;
         end
         S_FWR: begin
            prod_byte = rd_q_ff;
            if (prod_ok) begin
               prod_req = 1'b1;
               head_in  = head_inc;
               if (ret_ff == RET_WFULL) begin
                  wr_en   = 1'b1;
                  wr_addr = head_ff;
                  lho_in  = 1'b1;
                  if (!eidx_ff && ecnt_ff == 2'd2) begin
                     eidx_in = 1'b1;
                     st_in   = S_EMIT;
                  end else begin
                     st_in = S_DEC;
                  end
               end else begin
                  cnt_in = cnt_ff - CW'(1);
                  if (cnt_ff == CW'(1)) begin
                     st_in = (ret_ff == RET_CHAR) ? S_EMIT : S_ENL;
                  end else begin
                     st_in = S_FRD;
                  end
               end
            end
         end
         S_EOL: begin
            has_in = lho_ff || (keep_ff && cnt_ff != '0);
            if (keep_ff && cnt_ff != '0) begin
               ret_in = RET_EOL;
               st_in  = S_FRD;
            end else begin
               st_in = S_ENL;
            end
         end
         S_ENL: begin
            prod_byte = CH_NL;
            if (prod_ok) begin
               if (has_ff) begin
                  prod_req = nl_ff;
                  plb_in   = 1'b0;
               end else if (nl_ff && !inblk_ff && !plb_ff) begin
                  prod_req = 1'b1;
                  plb_in   = 1'b1;
               end
               cnt_in  = '0;
               n_in    = 3'd0;
               lho_in  = 1'b0;
               skip_in = 1'b0;
               if (eos_ff) begin
                  inblk_in = 1'b0;
                  keep_in  = 1'b0;
                  plb_in   = 1'b0;
               end
               st_in = S_FIN;
            end
         end
         S_FIN: begin
            if (!hold_v_ff) begin
               st_in = S_IDLE;
            end else if (can_push) begin
               push      = 1'b1;
               push_data = '{out_byte: hold_ff, last: 1'b1};
               st_in     = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase

      // A produced byte displaces the held one toward the output.
      hold_v_in = hold_v_ff;
      hold_in   = hold_ff;
      if (prod_req) begin
         if (hold_v_ff) begin
            push = 1'b1;
         end
         hold_v_in = 1'b1;
         hold_in   = prod_byte;
      end else if (push) begin
         hold_v_in = 1'b0;
      end

      out_v_in = out_v_ff;
      out_in   = out_ff;
      if (push) begin
         out_v_in = 1'b1;
         out_in   = push_data;
      end else if (rsp_ready) begin
         out_v_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= S_IDLE;
         inblk_ff  <= 1'b0;
         keep_ff   <= 1'b0;
         plb_ff    <= 1'b0;
         lho_ff    <= 1'b0;
         skip_ff   <= 1'b0;
         n_ff      <= 3'd0;
         cnt_ff    <= '0;
         head_ff   <= '0;
         hold_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         st_ff     <= st_in;
         inblk_ff  <= inblk_in;
         keep_ff   <= keep_in;
         plb_ff    <= plb_in;
         lho_ff    <= lho_in;
         skip_ff   <= skip_in;
         n_ff      <= n_in;
         cnt_ff    <= cnt_in;
         head_ff   <= head_in;
         hold_v_ff <= hold_v_in;
         out_v_ff  <= out_v_in;
      end
   end

   // Payload and per-transaction working registers.
   always_ff @(posedge clock) begin
      la_ff   <= la_in;
      fin_ff  <= fin_in;
      eol_ff  <= eol_in;
      nl_ff   <= nl_in;
      eos_ff  <= eos_in;
      e0_ff   <= e0_in;
      e1_ff   <= e1_in;
      ecnt_ff <= ecnt_in;
      eidx_ff <= eidx_in;
      ret_ff  <= ret_in;
      has_ff  <= has_in;
      hold_ff <= hold_in;
      out_ff  <= out_in;
   end

   // Held whitespace memory, circular from the head pointer.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         sp_mem[wr_addr] <= wr_data;
      end
      rd_q_ff <= sp_mem[head_ff];
   end

endmodule
`default_nettype wire

// File: rtl/comment_stripper_keep_doc_top.sv
`default_nettype none
// The queue registers each transaction ahead of the back end, which takes one at a time. A
// byte of a removed line rest goes straight to the finish state; others are decided on from
// the lookahead, after held whitespace is written out. A line end passes the decision,
// line-end and newline states, reading out kept whitespace first. A written byte waits in a
// one-byte hold until the next byte or transaction end, then enters the output register.
// Reset (synchronous, active high) clears the queue, parser flags and output valid.
module comment_stripper_keep_doc_top #(
   parameter int SPACE_DEPTH = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire cskd_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output cskd_pkg::rsp_type      rsp_data
);
   import cskd_pkg::*;

   logic    cmd_valid, cmd_ready;
   cmd_type cmd_data;

   // Front: accept and classify transactions into the queue.
   cskd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd_data  (cmd_data)
   );

   // Back: parse, trim whitespace and deliver result bytes.
   cskd_back #(
      .SPACE_DEPTH (SPACE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd_data  (cmd_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire
